@@ hw/rtl/multichannel_strided_conv2d_macros.svh @@
// Assertion macros shared by the convolution block.
`ifndef MULTICHANNEL_STRIDED_CONV2D_MACROS_SVH
`define MULTICHANNEL_STRIDED_CONV2D_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MSCONV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MSCONV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/msconv_pkg.sv @@
// Shared types and constants of the convolution block.
`default_nettype none
package msconv_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_FILTERS  = 8;
  localparam int DEF_MAX_KERNEL   = 5;

  localparam int MAX_HEIGHT = 4096;
  localparam int DIV_STEPS  = 12;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_FILTER_COUNT  = 3'd3;
  localparam logic [2:0] REG_KERNEL_SIZE   = 3'd4;
  localparam logic [2:0] REG_STRIDE        = 3'd5;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic div_step;
    logic start;
    logic first;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic window_accept;
    logic div_done;
    logic aligned;
    logic issue_last;
    logic acc_done;
    logic last_filter;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/multichannel_strided_conv2d.sv @@
// Weight items and pixel items that close no window are taken without a stall.
// A pixel closing a window passes the stride divider and a check state, then per
// filter the one shared multiplier before its result waits for the output handshake.
// Input stalls while a window is in work. rst (synchronous) clears counters and
// state and sets the registers to 256, 256, 1, 1, 3, 1; the stores are not cleared.
`default_nettype none
`include "multichannel_strided_conv2d_macros.svh"
module multichannel_strided_conv2d #(
  parameter int MAX_WIDTH    = msconv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = msconv_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = msconv_pkg::DEF_MAX_FILTERS,
  parameter int MAX_KERNEL   = msconv_pkg::DEF_MAX_KERNEL
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               write_enable,
  input  wire logic [2:0]         register_index,
  input  wire logic [12:0]        write_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               operation,
  input  wire logic signed [15:0] sample,
  input  wire logic [2:0]         weight_filter,
  input  wire logic [1:0]         weight_channel,
  input  wire logic [2:0]         weight_row,
  input  wire logic [2:0]         weight_col,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [2:0]         map_index,
  output      logic [11:0]        out_row,
  output      logic [7:0]         out_col,
  output      logic signed [47:0] sum,
  output      logic               last
);
  msconv_pkg::cmd_t    cmd;
  msconv_pkg::status_t status;
  logic                in_accept;

  assign in_accept = in_valid && !in_stall;

  msconv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .out_stall (out_stall),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  msconv_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILTERS  (MAX_FILTERS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_accept      (in_accept),
    .operation      (operation),
    .sample         (sample),
    .weight_filter  (weight_filter),
    .weight_channel (weight_channel),
    .weight_row     (weight_row),
    .weight_col     (weight_col),
    .cmd            (cmd),
    .status         (status),
    .map_index      (map_index),
    .out_row        (out_row),
    .out_col        (out_col),
    .sum            (sum),
    .last           (last)
  );

  `MSCONV_ASSERT_IMP(a_no_input_while_result, out_valid, in_stall)
  `MSCONV_ASSERT_NXT(a_next_filter_starts, out_valid && !out_stall && !last, !out_valid)
  `MSCONV_ASSERT_NXT(a_idle_after_last, out_valid && !out_stall && last, !in_stall)
endmodule
`default_nettype wire

@@ hw/rtl/msconv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module msconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/msconv_ctrl.sv @@
// Controller state machine of the convolution block.
`default_nettype none
module msconv_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire msconv_pkg::status_t status,
  input  wire logic                out_stall,
  output      msconv_pkg::cmd_t    cmd,
  output      logic                in_stall,
  output      logic                out_valid
);
  msconv_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msconv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      msconv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (status.window_accept) begin
          state_next = msconv_pkg::ST_DIVIDE;
        end
      end
      msconv_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = msconv_pkg::ST_CHECK;
        end
      end
      msconv_pkg::ST_CHECK: begin
        if (status.aligned) begin
          cmd.start  = 1'b1;
          cmd.first  = 1'b1;
          state_next = msconv_pkg::ST_MAC;
        end else begin
          state_next = msconv_pkg::ST_IDLE;
        end
      end
      msconv_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_next = msconv_pkg::ST_DRAIN;
        end
      end
      msconv_pkg::ST_DRAIN: begin
        if (status.acc_done) begin
          state_next = msconv_pkg::ST_EMIT;
        end
      end
      msconv_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.last_filter) begin
            state_next = msconv_pkg::ST_IDLE;
          end else begin
            cmd.start  = 1'b1;
            state_next = msconv_pkg::ST_MAC;
          end
        end
      end
      default: state_next = msconv_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/msconv_datapath.sv @@
// Datapath: configuration, counters, stores, stride divider and MAC pipeline.
`default_nettype none
module msconv_datapath #(
  parameter int MAX_WIDTH    = msconv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = msconv_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILTERS  = msconv_pkg::DEF_MAX_FILTERS,
  parameter int MAX_KERNEL   = msconv_pkg::DEF_MAX_KERNEL
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                write_enable,
  input  wire logic [2:0]          register_index,
  input  wire logic [12:0]         write_data,
  input  wire logic                in_accept,
  input  wire logic                operation,
  input  wire logic signed [15:0]  sample,
  input  wire logic [2:0]          weight_filter,
  input  wire logic [1:0]          weight_channel,
  input  wire logic [2:0]          weight_row,
  input  wire logic [2:0]          weight_col,
  input  wire msconv_pkg::cmd_t    cmd,
  output      msconv_pkg::status_t status,
  output      logic [2:0]          map_index,
  output      logic [11:0]         out_row,
  output      logic [7:0]          out_col,
  output      logic signed [47:0]  sum,
  output      logic                last
);
  localparam int CB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FB  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int KB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int LAW = KB + CB + HB;
  localparam int WAW = FB + HB + KB + KB;
  localparam int DB  = msconv_pkg::DIV_STEPS;

  // configuration registers
  logic [8:0]  image_width;
  logic [12:0] image_height;
  logic [2:0]  channel_count;
  logic [3:0]  filter_count;
  logic [2:0]  kernel_size;
  logic [2:0]  stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 9'd256;
      image_height  <= 13'd256;
      channel_count <= 3'd1;
      filter_count  <= 4'd1;
      kernel_size   <= 3'd3;
      stride        <= 3'd1;
    end else if (write_enable) begin
      case (register_index)
        msconv_pkg::REG_IMAGE_WIDTH:   image_width   <= write_data[8:0];
        msconv_pkg::REG_IMAGE_HEIGHT:  image_height  <= write_data;
        msconv_pkg::REG_CHANNEL_COUNT: channel_count <= write_data[2:0];
        msconv_pkg::REG_FILTER_COUNT:  filter_count  <= write_data[3:0];
        msconv_pkg::REG_KERNEL_SIZE:   kernel_size   <= write_data[2:0];
        msconv_pkg::REG_STRIDE:        stride        <= write_data[2:0];
        default: ;
      endcase
    end
  end

  // effective values: zero acts as one; all but the stride are capped at their limits
  logic [12:0] w_eff, h_eff;
  logic [2:0]  cc_eff, k_eff, s_eff;
  logic [3:0]  fc_eff;

  always_comb begin
    w_eff  = (image_width == 9'd0) ? 13'd1 :
             (32'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(image_width);
    h_eff  = (image_height == 13'd0) ? 13'd1 :
             (32'(image_height) > msconv_pkg::MAX_HEIGHT) ?
             13'(msconv_pkg::MAX_HEIGHT) : image_height;
    cc_eff = (channel_count == 3'd0) ? 3'd1 :
             (32'(channel_count) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : channel_count;
    fc_eff = (filter_count == 4'd0) ? 4'd1 :
             (32'(filter_count) > MAX_FILTERS) ? 4'(MAX_FILTERS) : filter_count;
    k_eff  = (kernel_size == 3'd0) ? 3'd1 :
             (32'(kernel_size) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kernel_size;
    s_eff  = (stride == 3'd0) ? 3'd1 : stride;
  end

  // stream position
  logic [11:0]   row;
  logic [7:0]    col;
  logic [HB-1:0] ch;
  logic [KB-1:0] rowmod;

  logic pix_accept, wgt_accept, ch_done, col_wrap, row_wrap, window;
  logic [11:0] top;
  logic [7:0]  left;
  logic [KB:0] rmtop_raw;

  always_comb begin
    pix_accept = in_accept && (operation == msconv_pkg::OP_PIXEL);
    wgt_accept = in_accept && (operation == msconv_pkg::OP_WEIGHT);
    ch_done    = (8'(ch) + 8'd1) >= 8'(cc_eff);
    col_wrap   = (13'(col) + 13'd1) >= w_eff;
    row_wrap   = (13'(row) + 13'd1) >= h_eff;
    window     = ((13'(row) + 13'd1) >= 13'(k_eff)) && ((9'(col) + 9'd1) >= 9'(k_eff));
    top        = 12'(13'(row) + 13'd1 - 13'(k_eff));
    left       = 8'(9'(col) + 9'd1 - 9'(k_eff));
    rmtop_raw  = (KB+1)'(rowmod) + (KB+1)'(MAX_KERNEL) - (KB+1)'(k_eff - 3'd1);
    if (32'(rmtop_raw) >= MAX_KERNEL) begin
      rmtop_raw = rmtop_raw - (KB+1)'(MAX_KERNEL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      ch     <= '0;
      rowmod <= '0;
    end else if (pix_accept) begin
      if (!ch_done) begin
        ch <= ch + 1'b1;
      end else begin
        ch <= '0;
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row    <= '0;
            rowmod <= '0;
          end else begin
            row    <= row + 12'd1;
            rowmod <= (32'(rowmod) == MAX_KERNEL - 1) ? '0 : rowmod + 1'b1;
          end
        end else begin
          col <= col + 8'd1;
        end
      end
    end
  end

  // stride divider: one quotient bit per cycle for row and column offsets
  logic [DB-1:0] dt, dl, qt, ql;
  logic [2:0]    rt, rl;
  logic [3:0]    dcnt;
  logic [3:0]    tmp_t, tmp_l;
  logic          ge_t, ge_l;

  always_comb begin
    tmp_t = {rt, dt[DB-1]};
    tmp_l = {rl, dl[DB-1]};
    ge_t  = tmp_t >= {1'b0, s_eff};
    ge_l  = tmp_l >= {1'b0, s_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (pix_accept && ch_done && window) begin
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 4'd1;
    end
  end

  logic [KB-1:0] rmtop;
  logic [7:0]    left_q;

  always_ff @(posedge clk) begin
    if (pix_accept && ch_done && window) begin
      dt     <= top;
      dl     <= DB'(left);
      left_q <= left;
      rmtop  <= KB'(rmtop_raw);
      rt     <= '0;
      rl     <= '0;
    end else if (cmd.div_step) begin
      rt <= ge_t ? 3'(tmp_t - {1'b0, s_eff}) : tmp_t[2:0];
      rl <= ge_l ? 3'(tmp_l - {1'b0, s_eff}) : tmp_l[2:0];
      qt <= {qt[DB-2:0], ge_t};
      ql <= {ql[DB-2:0], ge_l};
      dt <= {dt[DB-2:0], 1'b0};
      dl <= {dl[DB-2:0], 1'b0};
    end
  end

  // MAC issue counters
  logic [FB-1:0] f;
  logic [HB-1:0] ic;
  logic [KB-1:0] ir, iq;
  logic          q_end, r_end, c_end, issue_last;

  always_comb begin
    q_end      = (8'(iq) + 8'd1) >= 8'(k_eff);
    r_end      = (8'(ir) + 8'd1) >= 8'(k_eff);
    c_end      = (8'(ic) + 8'd1) >= 8'(cc_eff);
    issue_last = q_end && r_end && c_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f  <= '0;
      ic <= '0;
      ir <= '0;
      iq <= '0;
    end else if (cmd.start) begin
      f  <= cmd.first ? '0 : f + 1'b1;
      ic <= '0;
      ir <= '0;
      iq <= '0;
    end else if (cmd.issue) begin
      if (!q_end) begin
        iq <= iq + 1'b1;
      end else begin
        iq <= '0;
        if (!r_end) begin
          ir <= ir + 1'b1;
        end else begin
          ir <= '0;
          ic <= ic + 1'b1;
        end
      end
    end
  end

  // read and write addresses
  logic [KB:0]    rs_raw;
  logic [8:0]     pc;
  logic [LAW-1:0] line_raddr, line_waddr;
  logic [WAW-1:0] wgt_raddr, wgt_waddr;
  logic           line_we, wgt_we, pc_out;

  always_comb begin
    rs_raw = (KB+1)'(rmtop) + (KB+1)'(ir);
    if (32'(rs_raw) >= MAX_KERNEL) begin
      rs_raw = rs_raw - (KB+1)'(MAX_KERNEL);
    end
    pc         = 9'(left_q) + 9'(iq);
    pc_out     = 32'(pc) >= MAX_WIDTH;
    line_raddr = {KB'(rs_raw), CB'(pc), ic};
    wgt_raddr  = {f, ic, ir, iq};
    line_we    = pix_accept && (32'(col) < MAX_WIDTH) && (32'(ch) < MAX_CHANNELS);
    line_waddr = {rowmod, CB'(col), ch};
    wgt_we     = wgt_accept && (32'(weight_filter) < MAX_FILTERS) &&
                 (32'(weight_channel) < MAX_CHANNELS) &&
                 (32'(weight_row) < MAX_KERNEL) && (32'(weight_col) < MAX_KERNEL);
    wgt_waddr  = {FB'(weight_filter), HB'(weight_channel), KB'(weight_row),
                  KB'(weight_col)};
  end

  logic [15:0] line_rdata, wgt_rdata;

  msconv_ram #(.WIDTH(16), .DEPTH(2 ** LAW)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (sample),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  msconv_ram #(.WIDTH(16), .DEPTH(2 ** WAW)) u_weight_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (sample),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  // pipeline: read, multiply, accumulate
  logic               v1, l1, z1, v2, l2, z2;
  logic signed [31:0] prod;
  logic signed [47:0] acc, addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    l1   <= issue_last;
    z1   <= pc_out;
    l2   <= l1;
    z2   <= z1;
    prod <= $signed(line_rdata) * $signed(wgt_rdata);
  end

  always_comb begin
    addend = z2 ? 48'sd0 : {{16{prod[31]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && l2) begin
      sum       <= acc + addend;
      map_index <= 3'(f);
      out_row   <= qt;
      out_col   <= ql[7:0];
      last      <= (8'(f) + 8'd1) == 8'(fc_eff);
    end
  end

  always_comb begin
    status.window_accept = pix_accept && ch_done && window;
    status.div_done      = cmd.div_step && (32'(dcnt) == DB - 1);
    status.aligned       = (rt == 3'd0) && (rl == 3'd0);
    status.issue_last    = issue_last;
    status.acc_done      = v2 && l2;
    status.last_filter   = last;
  end
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the strided multichannel convolution block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         map;
    logic [11:0]        row;
    logic [7:0]         col;
    logic signed [47:0] total;
    logic               last;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [2:0] register_index = '0;
  logic [12:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = msconv_pkg::OP_WEIGHT;
  logic signed [15:0] sample = '0;
  logic [2:0] weight_filter = '0;
  logic [1:0] weight_channel = '0;
  logic [2:0] weight_row = '0;
  logic [2:0] weight_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] map_index;
  logic [11:0] out_row;
  logic [7:0] out_col;
  logic signed [47:0] sum;
  logic last;

  multichannel_strided_conv2d DUT (.*);

  conv_result_t expected_sums[$];
  int errors = 0;
  int cycle_count = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int burst_left = 0;

  // Shadow of the block: raw registers, stores and raster counters.
  logic [8:0] cfg_width = 9'd256;
  logic [12:0] cfg_height = 13'd256;
  logic [2:0] cfg_channels = 3'd1;
  logic [3:0] cfg_filters = 4'd1;
  logic [2:0] cfg_kernel = 3'd3;
  logic [2:0] cfg_stride = 3'd1;
  logic signed [15:0] weights [8][4][5][5];
  logic signed [15:0] lines [5][256][4];
  int pix_row = 0, pix_col = 0, pix_ch = 0;

  initial forever #1 clk = ~clk;

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int eff_width();    return clamp_reg(int'(cfg_width), 256);   endfunction
  function automatic int eff_height();   return clamp_reg(int'(cfg_height), 4096); endfunction
  function automatic int eff_channels(); return clamp_reg(int'(cfg_channels), 4);  endfunction
  function automatic int eff_filters();  return clamp_reg(int'(cfg_filters), 8);   endfunction
  function automatic int eff_kernel();   return clamp_reg(int'(cfg_kernel), 5);    endfunction
  function automatic int eff_stride();
    return (cfg_stride == 3'd0) ? 1 : int'(cfg_stride);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Store the sample and queue one sum per filter when a strided window closes.
  task automatic predict_pixel(logic signed [15:0] value);
    int w, h, cc, fc, k, s, top, left;
    longint acc;
    conv_result_t r;
    w = eff_width(); h = eff_height(); cc = eff_channels();
    fc = eff_filters(); k = eff_kernel(); s = eff_stride();
    if (pix_col < 256 && pix_ch < 4) lines[pix_row % 5][pix_col][pix_ch] = value;
    if (pix_ch + 1 < cc) begin
      pix_ch = (pix_ch + 1) & 3;
      return;
    end
    if (pix_row + 1 >= k && pix_col + 1 >= k &&
        (pix_row + 1 - k) % s == 0 && (pix_col + 1 - k) % s == 0) begin
      top = pix_row + 1 - k;
      left = pix_col + 1 - k;
      for (int f = 0; f < fc; f++) begin
        acc = 0;
        for (int c = 0; c < cc; c++)
          for (int i = 0; i < k; i++)
            for (int j = 0; j < k; j++)
              if (left + j < 256)
                acc += longint'(lines[(top + i) % 5][left + j][c]) *
                       longint'(weights[f][c][i][j]);
        r.map = 3'(f);
        r.row = 12'(top / s);
        r.col = 8'(left / s);
        r.total = acc[47:0];
        r.last = (f + 1 == fc);
        expected_sums.insert(expected_sums.size(), r);
      end
    end
    pix_ch = 0;
    if (pix_col + 1 >= w) begin
      pix_col = 0;
      pix_row = (pix_row + 1 >= h) ? 0 : ((pix_row + 1) & 12'hfff);
    end else begin
      pix_col = (pix_col + 1) & 8'hff;
    end
  endtask

  // Offer one transaction, with an optional gap ahead of it, and wait for acceptance.
  task automatic send_item(logic op, logic signed [15:0] value, logic [2:0] f,
                           logic [1:0] c, logic [2:0] r, logic [2:0] q);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample <= value;
    weight_filter <= f;
    weight_channel <= c;
    weight_row <= r;
    weight_col <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == msconv_pkg::OP_WEIGHT) begin
      if (r < 5 && q < 5) weights[f][c][r][q] = value;
    end else begin
      predict_pixel(value);
    end
  endtask

  // Drop valid, let every sum arrive, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, int value);
    write_enable <= 1'b1;
    register_index <= index;
    write_data <= 13'(value);
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, int cc, int fc, int k, int s);
    write_reg(msconv_pkg::REG_IMAGE_WIDTH, w);
    write_reg(msconv_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(msconv_pkg::REG_CHANNEL_COUNT, cc);
    write_reg(msconv_pkg::REG_FILTER_COUNT, fc);
    write_reg(msconv_pkg::REG_KERNEL_SIZE, k);
    write_reg(msconv_pkg::REG_STRIDE, s);
    write_enable <= 1'b0;
    cfg_width = 9'(w); cfg_height = 13'(h); cfg_channels = 3'(cc);
    cfg_filters = 4'(fc); cfg_kernel = 3'(k); cfg_stride = 3'(s);
  endtask

  task automatic load_weights();
    for (int f = 0; f < eff_filters(); f++)
      for (int c = 0; c < eff_channels(); c++)
        for (int r = 0; r < eff_kernel(); r++)
          for (int q = 0; q < eff_kernel(); q++)
            send_item(msconv_pkg::OP_WEIGHT, rand_sample(), 3'(f), 2'(c), 3'(r), 3'(q));
  endtask

  // Send one whole frame; with noise, stray weight writes land between pixels.
  task automatic run_frame(bit noise);
    int total;
    total = eff_width() * eff_height() * eff_channels();
    for (int i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        send_item(msconv_pkg::OP_WEIGHT, rand_sample(), 3'($urandom), 2'($urandom),
                  3'($urandom), 3'($urandom));
      send_item(msconv_pkg::OP_PIXEL, rand_sample(), 3'($urandom), 2'($urandom),
                3'($urandom), 3'($urandom));
    end
    drain();
  endtask

  task automatic test_directed();
    configure(2, 2, 2, 2, 2, 1);
    load_weights();
    // ignored: kernel row or column beyond the window store
    send_item(msconv_pkg::OP_WEIGHT, 16'sh7fff, 3'd7, 2'd3, 3'd5, 3'd0);
    send_item(msconv_pkg::OP_WEIGHT, 16'sh8000, 3'd0, 2'd0, 3'd0, 3'd7);
    send_item(msconv_pkg::OP_WEIGHT, 16'sh1234, 3'd1, 2'd1, 3'd6, 3'd6);
    for (int i = 0; i < 8; i++)
      send_item(msconv_pkg::OP_PIXEL, (i % 2) ? 16'sh8000 : 16'sh7fff,
                3'd7, 2'd3, 3'd7, 3'd7);
    drain();
  endtask

  task automatic test_register_extremes();
    configure(0, 0, 0, 0, 0, 0);
    load_weights();
    run_frame(1'b0);
    // channel and kernel counts capped, window wider than the image: no sums
    configure(2, 2, 7, 15, 7, 7);
    run_frame(1'b0);
    // filter count capped, stride larger than the image
    configure(2, 2, 1, 15, 1, 7);
    load_weights();
    run_frame(1'b0);
    configure(7, 2, 1, 3, 1, 6);
    load_weights();
    run_frame(1'b1);
  endtask

  task automatic test_pressure();
    configure(3, 3, 1, 4, 2, 1);
    load_weights();
    hold_request = 300;
    run_frame(1'b0);
  endtask

  task automatic random_phase();
    configure($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 2),
              $urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 7));
    load_weights();
    run_frame(1'b1);
  endtask

  task automatic test_random();
    do begin
      random_phase();
    end while (items_sent < 110);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    random_phase();
  endtask

  // Receiver: long hold-off on request, otherwise short random stall bursts.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: map_index %0d row %0d col %0d", map_index, out_row,
               out_col);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (map_index !== want.map) begin
          $error("map_index expected %0d got %0d", want.map, map_index); errors++;
        end
        if (out_row !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, out_row); errors++;
        end
        if (out_col !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, out_col); errors++;
        end
        if (sum !== want.total) begin
          $error("sum expected %0d got %0d", want.total, sum); errors++;
        end
        if (last !== want.last) begin
          $error("last expected %0d got %0d", want.last, last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_pressure();
    test_random();
    test_no_idle();
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
